FILE: hdl/keyed_value_cache_oldest_replace_top_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef KEYED_VALUE_CACHE_OLDEST_REPLACE_TOP_DEFINES_SVH
`define KEYED_VALUE_CACHE_OLDEST_REPLACE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define KVC_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");
`define KVC_ASSERT_NR(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) (prop)) else $error("assertion failed");
`else
`define KVC_ASSERT(label, clk_s, rst_s, prop)
`define KVC_ASSERT_NR(label, clk_s, prop)
`endif
`endif

FILE: hdl/kvc_pkg.sv
// Shared types and constants of the keyed value cache.
package kvc_pkg;
  localparam int SLOTS = 16;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [31:0] DEFAULT_INTERVAL = 32'd10000;

  localparam logic [2:0] K_SAVE = 3'd0, K_LOAD = 3'd1, K_FILL = 3'd2,
                         K_COMMIT = 3'd3, K_STATS = 3'd4, K_TICK = 3'd5;
  localparam logic [2:0] A_LOAD = 3'd0, A_SAVE = 3'd1, A_CWRITE = 3'd2,
                         A_CDONE = 3'd3, A_STATS = 3'd4, A_NONE = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input beat
    logic search;    // register hit/victim search
    logic apply;     // apply save/load/fill update and emit reply
    logic scan_rst;  // restart commit scan
    logic scan_step; // examine one slot in commit
    logic done_emit; // emit commit done
    logic other_emit;// emit stats or none
    logic tick_mark; // move last commit time
  } kvc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       tick_due;
    logic       scan_end;
  } kvc_stat_t;
endpackage

FILE: hdl/kvc_datapath.sv
// Slot store, search, counters and result register of the cache.
`include "keyed_value_cache_oldest_replace_top_defines.svh"
module kvc_datapath import kvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  kvc_cmd_t    cmd,
  output kvc_stat_t   stat,
  input  logic [2:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] data_value,
  input  logic        store_found,
  input  logic [31:0] now,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  action,
  output logic [31:0] out_key,
  output logic [31:0] out_value,
  output logic        ok,
  output logic        last,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count,
  output logic [31:0] write_count,
  output logic [31:0] read_count,
  output logic [4:0]  occupancy
);
  logic [31:0] slot_key [SLOTS];
  logic [31:0] slot_value [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [SLOTS-1:0] slot_dirty;
  logic [31:0] hits, misses, writes, reads, last_commit_time, commit_interval;
  logic [2:0]  r_kind;
  logic [31:0] r_key, r_val, r_now;
  logic        r_found;
  logic        hit, hit_next;
  logic [IW-1:0] hit_idx, hit_idx_next, vic_idx, vic_idx_next;
  logic [IW:0] scan;
  logic [CW-1:0] occ_next;
  logic [IW-1:0] si;

  assign si = scan[IW-1:0];

  // parallel key compare and victim choice
  always_comb begin
    logic [31:0] bt;
    logic        empty_found;
    hit_next = 1'b0;
    hit_idx_next = '0;
    vic_idx_next = '0;
    bt = slot_stamp[0];
    empty_found = 1'b0;
    occ_next = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_key[i] != 32'd0) occ_next = occ_next + CW'(1);
      if (!hit_next && r_key != 32'd0 && slot_key[i] == r_key) begin
        hit_next = 1'b1;
        hit_idx_next = IW'(i);
      end
    end
    for (int i = 1; i < SLOTS; i++) begin
      if (!empty_found) begin
        if (slot_key[i] == 32'd0) begin
          empty_found = 1'b1;
          vic_idx_next = IW'(i);
        end else if (slot_stamp[i] < bt) begin
          bt = slot_stamp[i];
          vic_idx_next = IW'(i);
        end
      end
    end
  end

  assign stat.kind = r_kind;
  assign stat.tick_due = (r_now - last_commit_time) >= commit_interval;
  assign stat.scan_end = scan[IW];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_kind <= kind; r_key <= key; r_val <= data_value;
      r_found <= store_found; r_now <= now;
    end
    if (cmd.search) begin
      hit <= hit_next; hit_idx <= hit_idx_next; vic_idx <= vic_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] <= '0; slot_value[i] <= '0; slot_stamp[i] <= '0;
      end
      slot_dirty <= '0;
      hits <= '0; misses <= '0; writes <= '0; reads <= '0;
      last_commit_time <= '0; commit_interval <= DEFAULT_INTERVAL;
      res_valid <= 1'b0; scan <= '0;
    end else begin
      if (cfg_we) commit_interval <= cfg_data;
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.tick_mark) last_commit_time <= r_now;
      if (cmd.scan_rst) scan <= '0;
      if (cmd.apply) begin
        res_valid <= 1'b1; last <= 1'b1;
        out_key <= r_key; hit_count <= '0; miss_count <= '0;
        write_count <= '0; read_count <= '0; occupancy <= '0;
        case (r_kind)
          K_SAVE: begin
            action <= A_SAVE;
            if (r_key == 32'd0) begin
              out_value <= '0; ok <= 1'b0;
            end else begin
              out_value <= r_val; ok <= 1'b1;
              writes <= writes + 32'd1;
              slot_key[hit ? hit_idx : vic_idx] <= r_key;
              slot_value[hit ? hit_idx : vic_idx] <= r_val;
              slot_stamp[hit ? hit_idx : vic_idx] <= r_now;
              slot_dirty[hit ? hit_idx : vic_idx] <= 1'b1;
            end
          end
          K_LOAD: begin
            action <= A_LOAD; ok <= hit;
            if (hit) begin
              hits <= hits + 32'd1;
              slot_stamp[hit_idx] <= r_now;
              out_value <= slot_value[hit_idx];
            end else begin
              misses <= misses + 32'd1;
              out_value <= r_val;
            end
          end
          default: begin
            action <= A_LOAD; ok <= r_found;
            out_value <= r_found ? r_val : 32'd0;
            if (r_found) begin
              reads <= reads + 32'd1;
              if (r_key != 32'd0 && !hit) begin
                slot_key[vic_idx] <= r_key;
                slot_value[vic_idx] <= r_val;
                slot_stamp[vic_idx] <= r_now;
                slot_dirty[vic_idx] <= 1'b0;
              end
            end
          end
        endcase
      end
      if (cmd.scan_step) begin
        scan <= scan + (IW+1)'(1);
        if (slot_dirty[si] && slot_key[si] != 32'd0) begin
          slot_dirty[si] <= 1'b0;
          writes <= writes + 32'd1;
          res_valid <= 1'b1; action <= A_CWRITE; out_key <= slot_key[si];
          out_value <= slot_value[si]; ok <= 1'b1; last <= 1'b0;
          hit_count <= '0; miss_count <= '0; write_count <= '0;
          read_count <= '0; occupancy <= '0;
        end
      end
      if (cmd.done_emit || cmd.other_emit) begin
        res_valid <= 1'b1; last <= 1'b1; out_key <= '0; out_value <= '0;
        hit_count <= '0; miss_count <= '0; write_count <= '0;
        read_count <= '0; occupancy <= '0;
        if (cmd.done_emit) begin
          action <= A_CDONE; ok <= 1'b1;
        end else if (r_kind == K_STATS) begin
          action <= A_STATS; ok <= 1'b0;
          hit_count <= hits; miss_count <= misses; write_count <= writes;
          read_count <= reads;
          occupancy <= (occ_next > CW'(31)) ? 5'd31 : 5'(occ_next);
        end else begin
          action <= A_NONE; ok <= 1'b0;
        end
      end
    end
  end

  `KVC_ASSERT(a_emit_free, clk, rst,
    (cmd.apply || cmd.done_emit || cmd.other_emit) |-> !res_valid)
  `KVC_ASSERT(a_hit_key, clk, rst,
    (cmd.apply && hit) |-> (slot_key[hit_idx] == r_key))
  `KVC_ASSERT(a_one_emit, clk, rst,
    $countones({cmd.apply, cmd.scan_step, cmd.done_emit, cmd.other_emit}) <= 1)
endmodule

FILE: hdl/kvc_ctrl.sv
// Sequencing state machine of the cache.
`include "keyed_value_cache_oldest_replace_top_defines.svh"
module kvc_ctrl import kvc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      res_valid,
  input  kvc_stat_t stat,
  output kvc_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DEC = 6'b000010, S_SRCH = 6'b000100,
    S_APPLY = 6'b001000, S_SCAN = 6'b010000, S_DONE = 6'b100000
  } state_t;
  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.capture = 1'b1; state_next = S_DEC;
      end
      S_DEC: begin
        case (stat.kind)
          K_SAVE, K_LOAD, K_FILL: state_next = S_SRCH;
          K_COMMIT: begin
            cmd.scan_rst = 1'b1; state_next = S_SCAN;
          end
          K_TICK: begin
            if (stat.tick_due) begin
              cmd.scan_rst = 1'b1; cmd.tick_mark = 1'b1; state_next = S_SCAN;
            end else if (!res_valid) begin
              cmd.other_emit = 1'b1; state_next = S_IDLE;
            end
          end
          default: if (!res_valid) begin
            cmd.other_emit = 1'b1; state_next = S_IDLE;
          end
        endcase
      end
      S_SRCH: begin
        cmd.search = 1'b1; state_next = S_APPLY;
      end
      S_APPLY: if (!res_valid) begin
        cmd.apply = 1'b1; state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_end) state_next = S_DONE;
        else if (!res_valid) cmd.scan_step = 1'b1;
      end
      S_DONE: if (!res_valid) begin
        cmd.done_emit = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `KVC_ASSERT(a_cap_idle, clk, rst, cmd.capture |-> (state == S_IDLE))
  `KVC_ASSERT(a_srch_apply, clk, rst, cmd.search |=> (state == S_APPLY))
  `KVC_ASSERT(a_done_after, clk, rst, cmd.done_emit |=> in_ready)
endmodule

FILE: hdl/keyed_value_cache_oldest_replace_top.sv
// Top level of the keyed value cache with oldest-stamp replacement.
// Use:
//  - Input channel (in_valid/in_ready) carries one request beat: kind, key,
//    data_value, store_found, now. One request is in flight at a time.
//  - Output channel (out_valid/out_ready) carries result beats; last marks
//    the final beat of a request.
//  - Configuration channel (cfg_valid/cfg_ready) writes commit_interval;
//    it is always ready.
// Save, load and fill results are registered after the accepted beat through
//  decode, a registered search over 16 slots and the update. Stats and none
//  results are registered from the decode state. A commit, or a tick that is
//  due, walks the slots one per cycle while no result beat waits, holds after
//  each write beat until it is taken, and then emits its done beat.
// The next request is accepted the cycle after the last result beat is
//  registered, so a new request is not taken before the last one is through.
// Reset clears all slots, counters and the last commit time, and loads the
//  interval default of 10000.
// When the receiver stalls, the result register holds and the sequencer
//  waits before producing the next beat.
module keyed_value_cache_oldest_replace_top import kvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] data_value,
  input  logic        store_found,
  input  logic [31:0] now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [31:0] out_key,
  output logic [31:0] out_value,
  output logic        ok,
  output logic        last,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count,
  output logic [31:0] write_count,
  output logic [31:0] read_count,
  output logic [4:0]  occupancy
);
  kvc_cmd_t  cmd;
  kvc_stat_t stat;

  // always take configuration beats
  assign cfg_ready = 1'b1;

  kvc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .res_valid(out_valid), .stat, .cmd
  );

  kvc_datapath u_dp (
    .clk, .rst, .cmd, .stat, .kind, .key, .data_value, .store_found, .now,
    .cfg_we(cfg_valid && cfg_ready), .cfg_data,
    .res_valid(out_valid), .res_ready(out_ready),
    .action, .out_key, .out_value, .ok, .last, .hit_count, .miss_count,
    .write_count, .read_count, .occupancy
  );
endmodule

FILE: bench/keyed_value_cache_oldest_replace_top_tb.sv
// Self-checking testbench of the keyed value cache with oldest-stamp replacement.
module keyed_value_cache_oldest_replace_top_tb;
  import kvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;   // longer than a full commit walk
  localparam int WRITE_CAP = 16;
  localparam logic [2:0] K_SPARE6 = 3'd6, K_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  act;
    logic [31:0] rkey;
    logic [31:0] rval;
    logic        rok;
    logic        rlast;
    logic [31:0] hitc;
    logic [31:0] missc;
    logic [31:0] writec;
    logic [31:0] readc;
    logic [4:0]  occ;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = K_SAVE;
  logic [31:0] key = '0;
  logic [31:0] data_value = '0;
  logic        store_found = 1'b0;
  logic [31:0] now = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  action;
  logic [31:0] out_key, out_value;
  logic        ok, last;
  logic [31:0] hit_count, miss_count, write_count, read_count;
  logic [4:0]  occupancy;

  keyed_value_cache_oldest_replace_top dut (.*);

  // Mirror of the cache contents and counters
  logic [31:0] mir_key [SLOTS];
  logic [31:0] mir_val [SLOTS];
  logic [31:0] mir_stamp [SLOTS];
  logic        mir_dirty [SLOTS];
  logic [31:0] mir_hits, mir_misses, mir_writes, mir_reads, mir_last_commit;
  logic [31:0] mir_interval;

  cache_result_t pending_results[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  beats_seen = 0;
  int  beats_taken = 0;
  int  commits_seen = 0;
  bit  no_idle = 1'b0;
  logic [31:0] clock_ms = 32'd0;
  logic [31:0] key_pool [20];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake must not stall the run forever
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void push_result(input logic [2:0] a, input logic [31:0] k,
                                      input logic [31:0] v, input logic o,
                                      input logic l);
    cache_result_t r;
    r = '0;
    r.act = a; r.rkey = k; r.rval = v; r.rok = o; r.rlast = l;
    pending_results.push_back(r);
  endfunction

  function automatic int find_slot(input logic [31:0] k);
    if (k == 0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (mir_key[i] == k) return i;
    return -1;
  endfunction

  // First empty slot from index 1, else oldest stamp with the lowest index taking ties
  function automatic int pick_victim();
    int best;
    best = 0;
    for (int i = 1; i < SLOTS; i++) begin
      if (mir_key[i] == 0) return i;
      if (mir_stamp[i] < mir_stamp[best]) best = i;
    end
    return best;
  endfunction

  function automatic int place_entry(input logic [31:0] k, input logic [31:0] v,
                                     input logic [31:0] t);
    int s;
    s = pick_victim();
    mir_key[s] = k; mir_val[s] = v; mir_stamp[s] = t; mir_dirty[s] = 1'b0;
    return s;
  endfunction

  function automatic void flush_dirty();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS && n < WRITE_CAP; i++)
      if (mir_dirty[i] && mir_key[i] != 0) begin
        push_result(A_CWRITE, mir_key[i], mir_val[i], 1'b1, 1'b0);
        mir_dirty[i] = 1'b0;
        mir_writes++;
        n++;
      end
    push_result(A_CDONE, '0, '0, 1'b1, 1'b1);
  endfunction

  // Work out the result beats of one accepted request and advance the mirror
  function automatic void predict_request(input logic [2:0] k, input logic [31:0] kv,
                                          input logic [31:0] v, input logic f,
                                          input logic [31:0] t);
    int s;
    int cnt;
    cache_result_t r;
    case (k)
      K_SAVE: begin
        if (kv == 0) push_result(A_SAVE, kv, '0, 1'b0, 1'b1);
        else begin
          s = find_slot(kv);
          if (s < 0) s = place_entry(kv, v, t);
          mir_val[s] = v; mir_stamp[s] = t; mir_dirty[s] = 1'b1;
          mir_writes++;
          push_result(A_SAVE, kv, v, 1'b1, 1'b1);
        end
      end
      K_LOAD: begin
        s = find_slot(kv);
        if (s >= 0) begin
          mir_hits++;
          mir_stamp[s] = t;
          push_result(A_LOAD, kv, mir_val[s], 1'b1, 1'b1);
        end else begin
          mir_misses++;
          push_result(A_LOAD, kv, v, 1'b0, 1'b1);
        end
      end
      K_FILL: begin
        if (f) begin
          mir_reads++;
          if (kv != 0 && find_slot(kv) < 0) void'(place_entry(kv, v, t));
          push_result(A_LOAD, kv, v, 1'b1, 1'b1);
        end else push_result(A_LOAD, kv, '0, 1'b0, 1'b1);
      end
      K_COMMIT: flush_dirty();
      K_STATS: begin
        cnt = 0;
        for (int i = 0; i < SLOTS; i++) if (mir_key[i] != 0) cnt++;
        r = '0;
        r.act = A_STATS; r.rlast = 1'b1;
        r.hitc = mir_hits; r.missc = mir_misses; r.writec = mir_writes;
        r.readc = mir_reads; r.occ = (cnt > 31) ? 5'd31 : 5'(cnt);
        pending_results.push_back(r);
      end
      K_TICK: begin
        if (32'(t - mir_last_commit) >= mir_interval) begin
          flush_dirty();
          mir_last_commit = t;
        end else push_result(A_NONE, '0, '0, 1'b0, 1'b1);
      end
      default: push_result(A_NONE, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Receiver: draw a stall per result beat, drive ready at the falling edge
  int ready_hold = 0;
  always @(negedge clk) begin
    if (beats_seen != beats_taken) begin
      beats_taken = beats_seen;
      ready_hold = no_idle ? 0 : $urandom_range(0, 5);
    end
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else out_ready <= 1'b1;
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (action == A_CDONE) commits_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, action", 32'(action), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (action !== want.act) report_mismatch("action", 32'(action), 32'(want.act));
        if (out_key !== want.rkey) report_mismatch("out_key", out_key, want.rkey);
        if (out_value !== want.rval) report_mismatch("out_value", out_value, want.rval);
        if (ok !== want.rok) report_mismatch("ok", 32'(ok), 32'(want.rok));
        if (last !== want.rlast) report_mismatch("last", 32'(last), 32'(want.rlast));
        if (hit_count !== want.hitc) report_mismatch("hit_count", hit_count, want.hitc);
        if (miss_count !== want.missc)
          report_mismatch("miss_count", miss_count, want.missc);
        if (write_count !== want.writec)
          report_mismatch("write_count", write_count, want.writec);
        if (read_count !== want.readc)
          report_mismatch("read_count", read_count, want.readc);
        if (occupancy !== want.occ)
          report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
      end
    end
  end

  // Send one request beat. Entered and left at a falling edge; valid stays high
  // on return so a back-to-back beat needs no second assignment in one step.
  task automatic send_request(input logic [2:0] k, input logic [31:0] kv,
                              input logic [31:0] v, input logic f,
                              input logic [31:0] t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; key <= kv; data_value <= v; store_found <= f; now <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_request(k, kv, v, f, t);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait for every expected beat, then let a possible trailing walk finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [31:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    mir_interval = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_request(K_SAVE, 32'd1, 32'h0, 1'b0, 32'd5);
    send_request(K_SAVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd6);
    send_request(K_SAVE, 32'h0, 32'h1234, 1'b0, 32'd7);       // zero key refused
    send_request(K_LOAD, 32'd1, 32'hDEAD_BEEF, 1'b0, 32'd8);  // hit
    send_request(K_LOAD, 32'h0, 32'hAAAA_AAAA, 1'b0, 32'd9);  // zero key misses
    send_request(K_LOAD, 32'h5555, 32'h5A5A_5A5A, 1'b0, 32'd9);
    send_request(K_FILL, 32'h5555, 32'h77, 1'b1, 32'd10);     // inserts
    send_request(K_FILL, 32'd1, 32'h99, 1'b1, 32'd11);        // already cached
    send_request(K_FILL, 32'h0, 32'h55, 1'b1, 32'd12);
    send_request(K_FILL, 32'h66, 32'h88, 1'b0, 32'd13);       // store lacked it
    send_request(K_STATS, 32'h0, 32'h0, 1'b0, 32'd14);
    send_request(K_COMMIT, 32'h0, 32'h0, 1'b0, 32'd15);
    send_request(K_COMMIT, 32'h0, 32'h0, 1'b0, 32'd16);       // nothing dirty
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd100);        // not yet due
    send_request(K_SAVE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'd200);
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd10000);      // due on the dot
    send_request(K_SPARE6, 32'h1, 32'h1, 1'b1, 32'd10001);
    send_request(K_SPARE7, 32'h1, 32'h1, 1'b1, 32'd10002);
    send_request(K_STATS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // Fill every slot, then force evictions with tied and ordered stamps
  task automatic test_replacement();
    for (int i = 0; i < 20; i++)
      send_request(K_SAVE, 32'h100 + 32'(i), $urandom, 1'b0, 32'd20000 + 32'(i / 4));
    send_request(K_COMMIT, 32'h0, 32'h0, 1'b0, 32'd21000);    // longest burst
    send_request(K_LOAD, 32'h100, 32'h0, 1'b0, 32'd21001);
    send_request(K_LOAD, 32'h113, 32'h0, 1'b0, 32'd21002);
    send_request(K_STATS, 32'h0, 32'h0, 1'b0, 32'd21003);
    wait_idle();
  endtask

  task automatic test_interval();
    write_interval(32'd1);
    send_request(K_SAVE, 32'h42, 32'h4242, 1'b0, 32'd30000);
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd30000);      // elapsed is large
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd30000);      // zero elapsed
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd30001);
    write_interval(32'hFFFF_FFFF);
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd30005);
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd30000);      // wraps to all ones
    write_interval(DEFAULT_INTERVAL);
    send_request(K_TICK, 32'h0, 32'h0, 1'b0, 32'd30001);
    wait_idle();
  endtask

  task automatic send_random_request();
    int pick;
    logic [2:0] k;
    logic [31:0] kv;
    pick = $urandom_range(0, 99);
    if (pick < 30) k = K_SAVE;
    else if (pick < 55) k = K_LOAD;
    else if (pick < 72) k = K_FILL;
    else if (pick < 78) k = K_COMMIT;
    else if (pick < 85) k = K_STATS;
    else if (pick < 96) k = K_TICK;
    else k = pick[0] ? K_SPARE6 : K_SPARE7;
    pick = $urandom_range(0, 99);
    if (pick < 8) kv = '0;
    else if (pick < 18) kv = $urandom;
    else kv = key_pool[$urandom_range(0, 19)];
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + 32'($urandom_range(0, 4000));
    send_request(k, kv, $urandom, 1'($urandom), clock_ms);
  endtask

  task automatic test_random();
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h1;
    for (int i = 2; i < 20; i++) key_pool[i] = $urandom | 32'h1;
    clock_ms = 32'd40000;
    for (int n = 0; n < 60; n++) begin
      no_idle = (n >= 20 && n < 35);        // a stretch at full rate
      if (n == 45) begin
        write_interval(32'($urandom_range(1, 6000)));
      end
      send_random_request();
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mir_key[i] = '0; mir_val[i] = '0; mir_stamp[i] = '0; mir_dirty[i] = 1'b0;
    end
    mir_hits = '0; mir_misses = '0; mir_writes = '0; mir_reads = '0;
    mir_last_commit = '0;
    mir_interval = DEFAULT_INTERVAL;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_replacement();
    test_interval();
    test_random();
    $display("Sent %0d requests, checked %0d result beats including %0d commits,",
             items_sent, beats_seen, commits_seen);
    $display("across replacement, interval settings and random traffic.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/kvc_pkg.sv
hdl/kvc_datapath.sv
hdl/kvc_ctrl.sv
hdl/keyed_value_cache_oldest_replace_top.sv
bench/keyed_value_cache_oldest_replace_top_tb.sv
